@@ src/positional_list_store_defines.svh @@
// Assertion macros for the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pls_pkg.sv @@
// Types and constants of the positional list store.
package pls_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_READ   = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOB  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_READ,
    S_PUT,
    S_DONE
  } state_t;

endpackage

@@ src/pls_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/positional_list_store.sv @@
// Positional list store: an ordered list of words addressed by position.
//
// The block keeps up to CAPACITY words in order and serves one request at a
// time: insert at a position (later entries move up by one), append at the
// end, read the entry at a position, or remove the entry at a position (later
// entries move down by one). Each request word on the slave side yields
// exactly one result word on the master side, carrying the read data (zero
// unless a read succeeded), a status (ok, position out of bounds, list full),
// the entry count after the request and an empty flag. The entries live in a
// simple dual-port RAM, and every move of an entry goes through its single
// read port and single write port, one entry per cycle, under a small
// sequencer; the number of entries that must move therefore sets the latency.
// An insert that shifts runs the sweep and then a put step, an insert or
// append at the end only the put step, a read one read step, a remove the
// sweep alone (no step when the last entry goes), and a request that fails
// its range or full check goes straight to its result. The slave side is
// ready only between requests, but a new request may be accepted while the
// previous result still waits on the master side; the finished result of the
// new request is then held until the old one is taken. The RAM needs no
// clearing after reset: only entries below the count are ever read, and every
// one of those has been written.
module positional_list_store #(
  parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF,
  localparam int POS_W     = $clog2(CAPACITY + 1),
  localparam int IN_W      = ((POS_W + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + POS_W + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Request side.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // position, item_value, zero padding
  input  logic [1:0]       s_tuser,   // action
  // Result side.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // read_value, status, entry_count,
                                      // empty flag, zero padding
);

  import pls_pkg::*;

  `include "positional_list_store_defines.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam logic [POS_W-1:0] CAP_V = POS_W'(CAPACITY);

  // Sequencer and request registers.
  state_t                state, state_next;
  action_t               act;
  status_t               stat;
  logic [POS_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] val;
  logic [POS_W-1:0]      count;

  // Shift sweep: cur is the next RAM address to read, last the final one,
  // wptr the address that the data now on the read port goes to.
  logic [AW-1:0]         cur, last, wptr;
  logic                  rd_more;
  logic                  pend;

  // Result registers.
  logic [DATA_WIDTH-1:0] o_rd;
  status_t               o_stat;
  logic [POS_W-1:0]      o_cnt;

  // RAM port signals.
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  // Request decode.
  action_t               in_act;
  logic [POS_W-1:0]      in_pos, pos_eff, cnt_m1;
  status_t               stat_in;
  logic                  need_shift;
  logic [AW-1:0]         cur_init, last_init;
  logic                  accept, load, up;

  assign accept = s_tvalid && s_tready;
  assign load   = (state == S_DONE) && (!m_tvalid || m_tready);
  assign up     = (act != ACT_REMOVE);
  assign in_act = action_t'(s_tuser);
  assign in_pos = s_tdata[POS_W-1:0];
  assign cnt_m1 = count - 1'b1;

  // Range and capacity checks, and the bounds of any shift sweep. An append
  // is an insert at the current count.
  always_comb begin
    pos_eff    = (in_act == ACT_APPEND) ? count : in_pos;
    stat_in    = STAT_OK;
    need_shift = 1'b0;
    cur_init   = cnt_m1[AW-1:0];
    last_init  = pos_eff[AW-1:0];
    case (in_act)
      ACT_INSERT, ACT_APPEND: begin
        if (pos_eff > count) begin
          stat_in = STAT_OOB;
        end else if (count == CAP_V) begin
          stat_in = STAT_FULL;
        end else begin
          need_shift = (pos_eff != count);
        end
      end
      ACT_READ: begin
        if (pos_eff >= count) begin
          stat_in = STAT_OOB;
        end
      end
      ACT_REMOVE: begin
        cur_init  = pos_eff[AW-1:0] + 1'b1;
        last_init = cnt_m1[AW-1:0];
        if (pos_eff >= count) begin
          stat_in = STAT_OOB;
        end else begin
          need_shift = (pos_eff != cnt_m1);
        end
      end
      default: begin
        stat_in = STAT_OOB;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat_in != STAT_OK) begin
            state_next = S_DONE;
          end else begin
            case (in_act)
              ACT_INSERT, ACT_APPEND: state_next = need_shift ? S_SHIFT : S_PUT;
              ACT_READ:               state_next = S_READ;
              ACT_REMOVE:             state_next = need_shift ? S_SHIFT : S_DONE;
              default:                state_next = S_DONE;
            endcase
          end
        end
      end
      S_SHIFT: begin
        if (!rd_more && pend) begin
          state_next = up ? S_PUT : S_DONE;
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_PUT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake and RAM ports.
  always_comb begin
    s_tready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = wptr;
    wr_data  = rd_data;
    rd_en    = 1'b0;
    rd_addr  = cur;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_SHIFT: begin
        wr_en = pend;
        rd_en = rd_more;
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = pos[AW-1:0];
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_data = val;
      end
      S_DONE: begin
        wr_en = 1'b0;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      rd_more  <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rd_more <= need_shift;
        pend    <= 1'b0;
      end else if (state == S_SHIFT) begin
        pend <= rd_more;
        if (rd_more && (cur == last)) begin
          rd_more <= 1'b0;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
        if (stat == STAT_OK) begin
          if (act == ACT_INSERT || act == ACT_APPEND) begin
            count <= count + 1'b1;
          end else if (act == ACT_REMOVE) begin
            count <= count - 1'b1;
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= in_act;
      pos  <= pos_eff;
      val  <= s_tdata[POS_W +: DATA_WIDTH];
      stat <= stat_in;
      cur  <= cur_init;
      last <= last_init;
    end else if (state == S_SHIFT && rd_more) begin
      wptr <= up ? (cur + 1'b1) : (cur - 1'b1);
      cur  <= up ? (cur - 1'b1) : (cur + 1'b1);
    end
    if (load) begin
      o_rd   <= (act == ACT_READ && stat == STAT_OK) ? rd_data : '0;
      o_stat <= stat;
      if (stat == STAT_OK && (act == ACT_INSERT || act == ACT_APPEND)) begin
        o_cnt <= count + 1'b1;
      end else if (stat == STAT_OK && act == ACT_REMOVE) begin
        o_cnt <= count - 1'b1;
      end else begin
        o_cnt <= count;
      end
    end
  end

  always_comb begin
    m_tdata                             = '0;
    m_tdata[DATA_WIDTH-1:0]             = o_rd;
    m_tdata[DATA_WIDTH +: 2]            = o_stat;
    m_tdata[DATA_WIDTH + 2 +: POS_W]    = o_cnt;
    m_tdata[DATA_WIDTH + 2 + POS_W]     = (o_cnt == '0);
  end

  pls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  `PLS_ASSERT_IMP(a_count_max, 1'b1, count <= CAP_V, "entry count beyond capacity")
  `PLS_ASSERT_IMP(a_no_write_idle, (state == S_IDLE || state == S_DONE), !wr_en,
                  "RAM written outside a shift or put step")
  `PLS_ASSERT_NXT(a_remove_count, (load && act == ACT_REMOVE && stat == STAT_OK),
                  count == $past(count) - 1'b1, "successful remove did not drop the count")
  `PLS_ASSERT_IMP(a_full_status, (m_tvalid && o_stat == STAT_FULL), o_cnt == CAP_V,
                  "full status reported on a list that is not full")

endmodule

@@ verif/pls_checker.sv @@
// Watches both channels of the positional list store, predicts each result and compares.
`timescale 1ns / 100ps

module pls_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // position, item_value, zero padding
  input  logic [1:0]  s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // read_value, status, entry_count, empty flag, zero padding
  output int          errors,
  output int          pending
);

  import pls_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    logic [31:0] read_value;
    status_t     status;
    logic [6:0]  entry_count;
    logic        empty_flag;
  } list_result_t;

  // Shadow copy of the list contents and its length.
  logic [31:0]  list_words [0:CAP-1];
  int           list_count;
  list_result_t expected_results [$];

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t apply_request(action_t act, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int           at;
    int           i;
    r.read_value = '0;
    r.status     = STAT_OK;
    at           = int'(pos);
    case (act)
      ACT_INSERT, ACT_APPEND: begin
        if (act == ACT_APPEND) at = list_count;
        // The range check takes precedence over the full check.
        if (at > list_count) begin
          r.status = STAT_OOB;
        end else if (list_count >= CAP) begin
          r.status = STAT_FULL;
        end else begin
          for (i = list_count; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = val;
          list_count++;
        end
      end
      ACT_READ: begin
        if (at >= list_count) r.status = STAT_OOB;
        else r.read_value = list_words[at];
      end
      default: begin
        if (at >= list_count) begin
          r.status = STAT_OOB;
        end else begin
          for (i = at; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
    endcase
    r.entry_count = 7'(list_count);
    r.empty_flag  = (list_count == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Results are taken before the request of the same edge is queued, which keeps
  // the queue in order whichever side moves first.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      errors     = 0;
      list_count = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, actual 0x%0h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", want.read_value, m_tdata[31:0]);
          check_field("status", want.status, m_tdata[33:32]);
          check_field("entry_count", want.entry_count, m_tdata[40:34]);
          check_field("empty_flag", want.empty_flag, m_tdata[41]);
          check_field("padding", 64'd0, m_tdata[47:42]);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(action_t'(s_tuser), s_tdata[6:0],
                                                 s_tdata[38:7]));
      pending <= expected_results.size();
    end
  end

endmodule

@@ verif/positional_list_store_tb.sv @@
// Stimulus, clocking and verdict for the positional list store.
`timescale 1ns / 100ps

module positional_list_store_tb;
  import pls_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int ITEMS     = 1900;
  localparam int MAX_GAP   = 14;
  localparam int HOLD_LONG = 500;

  // Random phases steer the list level: filling towards full, draining towards
  // empty, or wandering.
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // position, item_value, zero padding
  logic [1:0]  s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // read_value, status, entry_count, empty flag, zero padding

  int  errors;
  int  pending;
  int  list_fill;     // list length after every word sent so far, used to steer stimulus
  int  sent_words;
  bit  tx_burst;      // no idling on the request side while set
  bit  rx_burst;      // no stalls on the result side while set

  positional_list_store u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pls_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard limit on the run. The slowest correct run is roughly 1900 words times
  // the longest shift, the longest gap on both sides and the long hold-offs,
  // which stays well under a quarter of this.
  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  // Offers one request word after a random gap (none while tx_burst is set) and waits for it to be taken.
  // The level of the list is tracked only so that later words can be steered
  // towards the interesting regions.
  task automatic send_request(action_t act, logic [6:0] pos, logic [31:0] val);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, val, pos};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_words++;
    case (act)
      ACT_INSERT: if (int'(pos) <= list_fill && list_fill < CAP) list_fill++;
      ACT_APPEND: if (list_fill < CAP) list_fill++;
      ACT_REMOVE: if (int'(pos) < list_fill) list_fill--;
      default: ;
    endcase
  endtask

  // A position mostly inside the legal range for the action, leaning on both ends.
  function automatic logic [6:0] pick_position(action_t act);
    int top;
    int r;
    top = (act == ACT_INSERT) ? list_fill : list_fill - 1;
    if (top < 0) top = 0;
    r = $urandom_range(0, 3);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(top);
    return 7'($urandom_range(0, top));
  endfunction

  // Values mostly random across all 32 bits, with the extremes now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: draws a stall for every result word, sometimes runs without any,
  // and twice holds off for a long stretch so that the block backs up and
  // refuses further requests while the sender keeps offering.
  initial begin
    int taken;
    int gap;
    m_tready <= 1'b0;
    rx_burst = 1'b0;
    taken    = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (taken == 300 || taken == 1100) gap = HOLD_LONG;
      else gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    phase_t  phase;
    int      phase_left;
    int      r;
    action_t act;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= ACT_INSERT;
    rst       <= 1'b1;
    list_fill  = 0;
    sent_words = 0;
    tx_burst   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: requests on the empty list, inserts at the front, the end
    // and the middle, reads at both ends and just past the end, removes from the
    // middle, the end and the front, and out-of-range positions for every action.
    send_request(ACT_READ,   7'd0,   32'h1111_1111);
    send_request(ACT_REMOVE, 7'd0,   32'h0);
    send_request(ACT_INSERT, 7'd1,   32'h2222_2222);
    send_request(ACT_INSERT, 7'd0,   32'hFFFF_FFFF);
    send_request(ACT_APPEND, 7'd127, 32'h0000_0000);
    send_request(ACT_INSERT, 7'd0,   32'h8000_0001);
    send_request(ACT_INSERT, 7'd3,   32'h0000_FFFF);
    send_request(ACT_INSERT, 7'd2,   32'h1234_5678);
    send_request(ACT_READ,   7'd0,   32'h0);
    send_request(ACT_READ,   7'd4,   32'h0);
    send_request(ACT_READ,   7'd5,   32'h0);
    send_request(ACT_READ,   7'd127, 32'h0);
    send_request(ACT_INSERT, 7'd64,  32'hDEAD_BEEF);
    send_request(ACT_REMOVE, 7'd5,   32'h0);
    send_request(ACT_REMOVE, 7'd2,   32'h0);
    send_request(ACT_REMOVE, 7'd3,   32'h0);
    send_request(ACT_REMOVE, 7'd0,   32'h0);
    send_request(ACT_APPEND, 7'd0,   32'h7FFF_FFFF);
    send_request(ACT_REMOVE, 7'd127, 32'h0);
    send_request(ACT_REMOVE, 7'd0,   32'h0);
    send_request(ACT_REMOVE, 7'd0,   32'h0);
    send_request(ACT_REMOVE, 7'd0,   32'h0);
    send_request(ACT_READ,   7'd0,   32'h0);

    // Random part. Filling phases run long enough to reach a full list and
    // then keep pushing against it; draining phases run it dry again.
    phase_left = 0;
    phase      = PH_MIX;
    while (sent_words < ITEMS) begin
      if (phase_left == 0) begin
        phase      = phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(100, 200);
        tx_burst   = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Noise: any action at any position the field can carry.
        send_request(action_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                     pick_value());
      end else begin
        r = $urandom_range(0, 99);
        case (phase)
          PH_FILL:  act = (r < 45) ? ACT_INSERT : (r < 85) ? ACT_APPEND :
                          (r < 95) ? ACT_READ : ACT_REMOVE;
          PH_DRAIN: act = (r < 10) ? ACT_INSERT : (r < 20) ? ACT_APPEND :
                          (r < 40) ? ACT_READ : ACT_REMOVE;
          default:  act = action_t'(r % 4);
        endcase
        send_request(act, pick_position(act), pick_value());
      end
    end
    s_tvalid <= 1'b0;

    // Wait for the checker to count the last accepted word as outstanding.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
